// ----- hw/rtl/bfpa_pkg.sv -----
// Shared types and constants for the best-fit partition allocator.
`timescale 1ns / 1ps

package bfpa_pkg;

    localparam int PARTITIONS_DEF = 8;

    localparam int MODE_W   = 2;
    localparam int IDX_W    = 3;
    localparam int ADDR_W   = 16;
    localparam int OWNER_W  = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD    = 2'd0,
        MODE_ALLOC   = 2'd1,
        MODE_RELEASE = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_TOO_BIG = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_TAIL,
        S_FINISH,
        S_REPORT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic load;
        logic clear_res;
        logic reject;
        logic init_scan;
        logic issue;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              too_big;
        logic              last_addr;
    } t_dp_stat;

endpackage

// ----- hw/rtl/bfpa_ctrl.sv -----
// Sequencing state machine of the best-fit partition allocator.
`timescale 1ns / 1ps

module bfpa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  bfpa_pkg::t_dp_stat i_stat,
    output bfpa_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_report
);
    import bfpa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE, S_REPORT: begin
                // the result cycle doubles as an idle cycle
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DISPATCH: begin
                case (i_stat.mode)
                    MODE_LOAD: begin
                        o_cmd.load      = 1'b1;
                        o_cmd.clear_res = 1'b1;
                        n_state         = S_REPORT;
                    end
                    MODE_ALLOC: begin
                        if (i_stat.too_big) begin
                            o_cmd.reject = 1'b1;
                            n_state      = S_REPORT;
                        end else begin
                            o_cmd.init_scan = 1'b1;
                            n_state         = S_SCAN;
                        end
                    end
                    MODE_RELEASE: begin
                        o_cmd.init_scan = 1'b1;
                        n_state         = S_SCAN;
                    end
                    default: begin
                        o_cmd.clear_res = 1'b1;
                        n_state         = S_REPORT;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.last_addr) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                // last table read is evaluated here
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_REPORT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = !((r_state == S_IDLE) || (r_state == S_REPORT));
    assign o_report = (r_state == S_REPORT);

endmodule

// ----- hw/rtl/bfpa_dpath.sv -----
// Partition table, sequential best-fit / release scan and result registers.
`timescale 1ns / 1ps

module bfpa_dpath #(
    parameter int PARTITIONS = bfpa_pkg::PARTITIONS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bfpa_pkg::t_dp_cmd              i_cmd,
    output bfpa_pkg::t_dp_stat             o_stat,
    input  logic                           i_cfg_wr_en,
    input  logic [bfpa_pkg::ADDR_W-1:0]    i_cfg_wr_data,
    input  logic [bfpa_pkg::MODE_W-1:0]    i_mode,
    input  logic [bfpa_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [bfpa_pkg::ADDR_W-1:0]    i_entry_base,
    input  logic [bfpa_pkg::ADDR_W-1:0]    i_entry_size,
    input  logic [bfpa_pkg::ADDR_W-1:0]    i_request_size,
    input  logic [bfpa_pkg::OWNER_W-1:0]   i_owner_id,
    output logic [bfpa_pkg::STATUS_W-1:0]  o_status,
    output logic [bfpa_pkg::IDX_W-1:0]     o_granted_index,
    output logic [bfpa_pkg::ADDR_W-1:0]    o_granted_base,
    output logic [bfpa_pkg::ADDR_W-1:0]    o_granted_size,
    output logic [bfpa_pkg::COUNT_W-1:0]   o_released_count
);
    import bfpa_pkg::*;

    localparam int IW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int WW = IW + IDX_W;
    localparam logic [WW-1:0] SLOT_LIMIT = WW'(PARTITIONS);
    localparam logic [IW-1:0] LAST_ADDR  = IW'(PARTITIONS - 1);

    // configuration
    logic [ADDR_W-1:0]  r_max_req;

    // captured command
    logic [MODE_W-1:0]  r_mode;
    logic [IDX_W-1:0]   r_slot;
    logic [ADDR_W-1:0]  r_ebase;
    logic [ADDR_W-1:0]  r_esize;
    logic [ADDR_W-1:0]  r_req;
    logic [OWNER_W-1:0] r_owner;

    // table
    logic [PARTITIONS-1:0] r_valid;
    logic [PARTITIONS-1:0] r_busy;
    logic [ADDR_W-1:0]     r_base_mem  [PARTITIONS];
    logic [ADDR_W-1:0]     r_len_mem   [PARTITIONS];
    logic [OWNER_W-1:0]    r_owner_mem [PARTITIONS];

    // scan
    logic [IW-1:0]      r_addr;
    logic               r_rd_vld;
    logic [IW-1:0]      r_rd_idx;
    logic [ADDR_W-1:0]  r_rd_base;
    logic [ADDR_W-1:0]  r_rd_len;
    logic [OWNER_W-1:0] r_rd_owner;
    logic               r_found;
    logic [IW-1:0]      r_best_idx;
    logic [ADDR_W-1:0]  r_best_len;
    logic [ADDR_W-1:0]  r_best_base;
    logic [COUNT_W-1:0] r_count;

    // result
    t_status            r_status;
    logic [IDX_W-1:0]   r_gidx;
    logic [ADDR_W-1:0]  r_gbase;
    logic [ADDR_W-1:0]  r_gsize;
    logic [COUNT_W-1:0] r_rcount;

    logic [WW-1:0] slot_wide;
    logic [IW-1:0] slot_addr;
    logic          slot_ok;
    logic [WW-1:0] best_wide;
    logic          is_alloc;
    logic          is_release;
    logic          fit;
    logic          better;
    logic          rel_hit;
    logic          alloc_win;

    assign slot_wide  = {{IW{1'b0}}, r_slot};
    assign slot_addr  = slot_wide[IW-1:0];
    assign slot_ok    = (slot_wide < SLOT_LIMIT);
    assign best_wide  = {{IDX_W{1'b0}}, r_best_idx};
    assign is_alloc   = (r_mode == MODE_ALLOC);
    assign is_release = (r_mode == MODE_RELEASE);

    assign fit     = r_valid[r_rd_idx] && !r_busy[r_rd_idx] && (r_rd_len >= r_req);
    // strict compare keeps the lowest index on equal sizes
    assign better  = r_rd_vld && is_alloc && fit && (!r_found || (r_rd_len < r_best_len));
    assign rel_hit = r_rd_vld && is_release && r_valid[r_rd_idx] && r_busy[r_rd_idx]
                     && (r_rd_owner == r_owner);
    assign alloc_win = i_cmd.finish && is_alloc && r_found;

    assign o_stat.mode      = r_mode;
    assign o_stat.too_big   = (r_req > r_max_req);
    assign o_stat.last_addr = (r_addr == LAST_ADDR);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_req <= '1;
            r_valid   <= '0;
            r_busy    <= '0;
            r_rd_vld  <= 1'b0;
            r_addr    <= '0;
            r_found   <= 1'b0;
            r_count   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_req <= i_cfg_wr_data;
            end
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.init_scan) begin
                r_addr  <= '0;
                r_found <= 1'b0;
                r_count <= '0;
            end else begin
                if (i_cmd.issue) begin
                    r_addr <= r_addr + IW'(1);
                end
                if (better) begin
                    r_found <= 1'b1;
                end
                if (rel_hit) begin
                    r_count <= r_count + COUNT_W'(1);
                end
            end
            if (rel_hit) begin
                r_busy[r_rd_idx] <= 1'b0;
            end
            if (i_cmd.load && slot_ok) begin
                r_valid[slot_addr] <= 1'b1;
                r_busy[slot_addr]  <= 1'b0;
            end
            if (alloc_win) begin
                r_busy[r_best_idx] <= 1'b1;
            end
        end
    end

    // table storage, one read port walked by the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && slot_ok) begin
            r_base_mem[slot_addr] <= r_ebase;
            r_len_mem[slot_addr]  <= r_esize;
        end
        if (alloc_win) begin
            r_owner_mem[r_best_idx] <= r_owner;
        end
        if (i_cmd.issue) begin
            r_rd_base  <= r_base_mem[r_addr];
            r_rd_len   <= r_len_mem[r_addr];
            r_rd_owner <= r_owner_mem[r_addr];
            r_rd_idx   <= r_addr;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_slot  <= i_entry_index;
            r_ebase <= i_entry_base;
            r_esize <= i_entry_size;
            r_req   <= i_request_size;
            r_owner <= i_owner_id;
        end
        if (better) begin
            r_best_idx  <= r_rd_idx;
            r_best_len  <= r_rd_len;
            r_best_base <= r_rd_base;
        end
        if (i_cmd.clear_res || i_cmd.reject) begin
            r_status <= i_cmd.reject ? ST_TOO_BIG : ST_OK;
            r_gidx   <= '0;
            r_gbase  <= '0;
            r_gsize  <= '0;
            r_rcount <= '0;
        end else if (i_cmd.finish) begin
            r_rcount <= is_release ? r_count : '0;
            if (is_alloc && r_found) begin
                r_status <= ST_OK;
                r_gidx   <= best_wide[IDX_W-1:0];
                r_gbase  <= r_best_base;
                r_gsize  <= r_best_len;
            end else begin
                r_status <= is_alloc ? ST_FULL : ST_OK;
                r_gidx   <= '0;
                r_gbase  <= '0;
                r_gsize  <= '0;
            end
        end
    end

    assign o_status         = r_status;
    assign o_granted_index  = r_gidx;
    assign o_granted_base   = r_gbase;
    assign o_granted_size   = r_gsize;
    assign o_released_count = r_rcount;

endmodule

// ----- hw/rtl/best_fit_partition_allocator_unit.sv -----
// Top level of the best-fit partition allocator: controller plus datapath.
`timescale 1ns / 1ps

// A command is taken on a clock edge where start is high and busy is low, and
// exactly one result follows, shown for one cycle with o_result_valid; the
// receiver cannot stall it, so sample it in that cycle. Load and undefined
// commands, and allocate requests above max_request_size, go from dispatch
// straight to the result. Allocate and release walk the partition table
// through its single read port, one entry per cycle, then pass through the
// tail and finish states before the result appears. busy is low again in the
// result cycle, so the next command may be taken there; none is taken while
// busy is high. Write max_request_size only while busy is low.
module best_fit_partition_allocator_unit #(
    parameter int PARTITIONS = bfpa_pkg::PARTITIONS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_wr_en,
    input  logic [bfpa_pkg::ADDR_W-1:0]    i_cfg_wr_data,
    input  logic [bfpa_pkg::MODE_W-1:0]    i_mode,
    input  logic [bfpa_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [bfpa_pkg::ADDR_W-1:0]    i_entry_base,
    input  logic [bfpa_pkg::ADDR_W-1:0]    i_entry_size,
    input  logic [bfpa_pkg::ADDR_W-1:0]    i_request_size,
    input  logic [bfpa_pkg::OWNER_W-1:0]   i_owner_id,
    output logic                           o_result_valid,
    output logic [bfpa_pkg::STATUS_W-1:0]  o_status,
    output logic [bfpa_pkg::IDX_W-1:0]     o_granted_index,
    output logic [bfpa_pkg::ADDR_W-1:0]    o_granted_base,
    output logic [bfpa_pkg::ADDR_W-1:0]    o_granted_size,
    output logic [bfpa_pkg::COUNT_W-1:0]   o_released_count
);
    import bfpa_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    bfpa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (dp_stat),
        .o_cmd    (dp_cmd),
        .o_busy   (busy),
        .o_report (o_result_valid)
    );

    bfpa_dpath #(
        .PARTITIONS (PARTITIONS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_mode           (i_mode),
        .i_entry_index    (i_entry_index),
        .i_entry_base     (i_entry_base),
        .i_entry_size     (i_entry_size),
        .i_request_size   (i_request_size),
        .i_owner_id       (i_owner_id),
        .o_status         (o_status),
        .o_granted_index  (o_granted_index),
        .o_granted_base   (o_granted_base),
        .o_granted_size   (o_granted_size),
        .o_released_count (o_released_count)
    );

`ifndef SYNTH
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    a_result_frees_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_full_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_status == ST_FULL || o_status == ST_TOO_BIG))
        |-> (o_granted_size == '0 && o_granted_base == '0 && o_granted_index == '0))
        else $error("grant fields set on a failed allocate");
`endif

endmodule

// ----- dv/bfpa_grant_checker.sv -----
// Checker for the partition allocator: predicts each result and compares it.
`timescale 1ns / 1ps

module bfpa_grant_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic                          i_cfg_wr_en,
    input  logic [bfpa_pkg::ADDR_W-1:0]   i_cfg_wr_data,
    input  logic [bfpa_pkg::MODE_W-1:0]   i_mode,
    input  logic [bfpa_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [bfpa_pkg::ADDR_W-1:0]   i_entry_base,
    input  logic [bfpa_pkg::ADDR_W-1:0]   i_entry_size,
    input  logic [bfpa_pkg::ADDR_W-1:0]   i_request_size,
    input  logic [bfpa_pkg::OWNER_W-1:0]  i_owner_id,
    input  logic                          i_result_valid,
    input  logic [bfpa_pkg::STATUS_W-1:0] i_status,
    input  logic [bfpa_pkg::IDX_W-1:0]    i_granted_index,
    input  logic [bfpa_pkg::ADDR_W-1:0]   i_granted_base,
    input  logic [bfpa_pkg::ADDR_W-1:0]   i_granted_size,
    input  logic [bfpa_pkg::COUNT_W-1:0]  i_released_count,
    output int                            o_pending,
    output int                            o_fail_count
);
    import bfpa_pkg::*;

    localparam int SLOTS = PARTITIONS_DEF;

    typedef struct packed {
        t_status              status;
        logic [IDX_W-1:0]     index;
        logic [ADDR_W-1:0]    base;
        logic [ADDR_W-1:0]    size;
        logic [COUNT_W-1:0]   count;
    } t_grant;

    logic                part_valid [SLOTS];
    logic                part_busy  [SLOTS];
    logic [OWNER_W-1:0]  part_owner [SLOTS];
    logic [ADDR_W-1:0]   part_base  [SLOTS];
    logic [ADDR_W-1:0]   part_len   [SLOTS];
    logic [ADDR_W-1:0]   max_request;
    t_grant              grant_q [$];
    int                  fails = 0;

    // Update the partition table for one command and return the result it owes.
    function automatic t_grant apply_command(
        input logic [MODE_W-1:0]  mode,
        input logic [IDX_W-1:0]   slot,
        input logic [ADDR_W-1:0]  ebase,
        input logic [ADDR_W-1:0]  esize,
        input logic [ADDR_W-1:0]  req,
        input logic [OWNER_W-1:0] owner
    );
        t_grant res;
        int     pick;
        int     freed;
        res   = '0;
        res.status = ST_OK;
        pick  = -1;
        freed = 0;
        case (mode)
            MODE_LOAD: begin
                if (slot < SLOTS) begin
                    part_base[slot]  = ebase;
                    part_len[slot]   = esize;
                    part_valid[slot] = 1'b1;
                    part_busy[slot]  = 1'b0;
                end
            end
            MODE_ALLOC: begin
                if (req > max_request) begin
                    res.status = ST_TOO_BIG;
                end else begin
                    // Strict less-than keeps the lowest index on equal lengths.
                    for (int k = 0; k < SLOTS; k++) begin
                        if (part_valid[k] && !part_busy[k] && part_len[k] >= req &&
                            (pick < 0 || part_len[k] < part_len[pick]))
                            pick = k;
                    end
                    if (pick < 0) begin
                        res.status = ST_FULL;
                    end else begin
                        part_busy[pick]  = 1'b1;
                        part_owner[pick] = owner;
                        res.index = IDX_W'(pick);
                        res.base  = part_base[pick];
                        res.size  = part_len[pick];
                    end
                end
            end
            MODE_RELEASE: begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (part_valid[k] && part_busy[k] && part_owner[k] == owner) begin
                        part_busy[k] = 1'b0;
                        freed++;
                    end
                end
                res.count = COUNT_W'(freed);
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                part_valid[k] = 1'b0;
                part_busy[k]  = 1'b0;
            end
            max_request = '1;
            grant_q.delete();
        end else begin
            // Retire the oldest result before queuing a command taken on this edge.
            if (i_result_valid) begin
                if (grant_q.size() == 0) begin
                    $error("result with no command outstanding");
                    fails++;
                end else begin
                    want = grant_q.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fails++;
                    end
                    if (i_granted_index !== want.index) begin
                        $error("granted_index: expected %0d, actual %0d",
                               want.index, i_granted_index);
                        fails++;
                    end
                    if (i_granted_base !== want.base) begin
                        $error("granted_base: expected 0x%04h, actual 0x%04h",
                               want.base, i_granted_base);
                        fails++;
                    end
                    if (i_granted_size !== want.size) begin
                        $error("granted_size: expected %0d, actual %0d",
                               want.size, i_granted_size);
                        fails++;
                    end
                    if (i_released_count !== want.count) begin
                        $error("released_count: expected %0d, actual %0d",
                               want.count, i_released_count);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy)
                grant_q.push_back(apply_command(i_mode, i_entry_index, i_entry_base,
                                                i_entry_size, i_request_size, i_owner_id));
            if (i_cfg_wr_en)
                max_request = i_cfg_wr_data;
        end
        o_pending    <= grant_q.size();
        o_fail_count <= fails;
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top: drives allocator commands and register writes, gives the verdict.
`timescale 1ns / 1ps

module tb;
    import bfpa_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 225;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                start          = 1'b0;
    logic                i_cfg_wr_en    = 1'b0;
    logic [ADDR_W-1:0]   i_cfg_wr_data  = '0;
    logic [MODE_W-1:0]   i_mode         = '0;
    logic [IDX_W-1:0]    i_entry_index  = '0;
    logic [ADDR_W-1:0]   i_entry_base   = '0;
    logic [ADDR_W-1:0]   i_entry_size   = '0;
    logic [ADDR_W-1:0]   i_request_size = '0;
    logic [OWNER_W-1:0]  i_owner_id     = '0;

    logic                busy;
    logic                o_result_valid;
    logic [STATUS_W-1:0] o_status;
    logic [IDX_W-1:0]    o_granted_index;
    logic [ADDR_W-1:0]   o_granted_base;
    logic [ADDR_W-1:0]   o_granted_size;
    logic [COUNT_W-1:0]  o_released_count;

    int pending;
    int fail_count;
    int stall_cycles = 0;
    bit steady       = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    best_fit_partition_allocator_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_mode           (i_mode),
        .i_entry_index    (i_entry_index),
        .i_entry_base     (i_entry_base),
        .i_entry_size     (i_entry_size),
        .i_request_size   (i_request_size),
        .i_owner_id       (i_owner_id),
        .o_result_valid   (o_result_valid),
        .o_status         (o_status),
        .o_granted_index  (o_granted_index),
        .o_granted_base   (o_granted_base),
        .o_granted_size   (o_granted_size),
        .o_released_count (o_released_count)
    );

    bfpa_grant_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_mode           (i_mode),
        .i_entry_index    (i_entry_index),
        .i_entry_base     (i_entry_base),
        .i_entry_size     (i_entry_size),
        .i_request_size   (i_request_size),
        .i_owner_id       (i_owner_id),
        .i_result_valid   (o_result_valid),
        .i_status         (o_status),
        .i_granted_index  (o_granted_index),
        .i_granted_base   (o_granted_base),
        .i_granted_size   (o_granted_size),
        .i_released_count (o_released_count),
        .o_pending        (pending),
        .o_fail_count     (fail_count)
    );

    // Abort when no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic issue_cmd(
        input logic [MODE_W-1:0]  mode,
        input logic [IDX_W-1:0]   slot,
        input logic [ADDR_W-1:0]  ebase,
        input logic [ADDR_W-1:0]  esize,
        input logic [ADDR_W-1:0]  req,
        input logic [OWNER_W-1:0] owner
    );
        int gap;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_mode         <= mode;
        i_entry_index  <= slot;
        i_entry_base   <= ebase;
        i_entry_size   <= esize;
        i_request_size <= req;
        i_owner_id     <= owner;
        // Hold until the block takes the command.
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_max_request(input logic [ADDR_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int                  sel;
        logic [MODE_W-1:0]   mode;
        logic [ADDR_W-1:0]   esize;
        logic [ADDR_W-1:0]   req;
        logic [OWNER_W-1:0]  owner;
        logic [ADDR_W-1:0]   limit;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: allocate finds nothing, release frees nothing; then an undefined command and the first loads.
        issue_cmd(MODE_ALLOC,   3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0);
        issue_cmd(MODE_RELEASE, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0);
        issue_cmd(MODE_UNDEF,   3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
        issue_cmd(MODE_LOAD,    3'd0, 16'hFFFF, 16'hFFFF, 16'h0000, 4'd0);
        issue_cmd(MODE_LOAD,    3'd7, 16'h0000, 16'h0000, 16'h0000, 4'd0);
        issue_cmd(MODE_LOAD,    3'd3, 16'h1234, 16'd100,  16'h0000, 4'd0);
        issue_cmd(MODE_LOAD,    3'd5, 16'hABCD, 16'd100,  16'h0000, 4'd0);
        issue_cmd(MODE_LOAD,    3'd1, 16'h0F0F, 16'd50,   16'h0000, 4'd0);
        // Zero request takes the zero-length slot; equal lengths go low index first.
        issue_cmd(MODE_ALLOC,   3'd0, 16'h0000, 16'h0000, 16'd0,    4'd15);
        issue_cmd(MODE_ALLOC,   3'd0, 16'h0000, 16'h0000, 16'd60,   4'd15);
        issue_cmd(MODE_ALLOC,   3'd0, 16'h0000, 16'h0000, 16'd60,   4'd15);
        issue_cmd(MODE_ALLOC,   3'd0, 16'h0000, 16'h0000, 16'hFFFF, 4'd9);
        issue_cmd(MODE_ALLOC,   3'd0, 16'h0000, 16'h0000, 16'd1,    4'd9);
        issue_cmd(MODE_ALLOC,   3'd0, 16'h0000, 16'h0000, 16'd1,    4'd9);
        issue_cmd(MODE_RELEASE, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd15);
        issue_cmd(MODE_RELEASE, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd9);
        issue_cmd(MODE_LOAD,    3'd2, 16'h2000, 16'd7,    16'h0000, 4'd0);
        issue_cmd(MODE_LOAD,    3'd4, 16'h4000, 16'd7,    16'h0000, 4'd0);
        issue_cmd(MODE_LOAD,    3'd6, 16'h6000, 16'd3000, 16'h0000, 4'd0);
        // Fill every slot for one owner, overflow once, then free them all.
        for (int k = 0; k < PARTITIONS_DEF + 1; k++)
            issue_cmd(MODE_ALLOC, 3'd0, 16'h0000, 16'h0000, 16'd0, 4'd4);
        issue_cmd(MODE_RELEASE, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd4);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       limit = 16'hFFFF;
                1:       limit = 16'd0;
                2:       limit = 16'd40;
                3:       limit = ADDR_W'($urandom);
                4:       limit = ADDR_W'($urandom_range(1, 80));
                default: limit = 16'hFFFF;
            endcase
            write_max_request(limit);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel  = $urandom_range(0, 99);
                mode = (sel < 15) ? MODE_LOAD :
                       (sel < 65) ? MODE_ALLOC :
                       (sel < 96) ? MODE_RELEASE : MODE_UNDEF;
                esize = ($urandom_range(0, 4) == 0) ? ADDR_W'($urandom)
                                                    : ADDR_W'($urandom_range(0, 63));
                sel = $urandom_range(0, 19);
                req = (sel == 0) ? 16'hFFFF :
                      (sel == 1) ? 16'h0000 :
                      (sel <  4) ? ADDR_W'($urandom) : ADDR_W'($urandom_range(0, 70));
                // Keep owners mostly in a small set so releases find something.
                owner = ($urandom_range(0, 4) == 0) ? OWNER_W'($urandom_range(0, 15))
                                                    : OWNER_W'($urandom_range(0, 3));
                issue_cmd(mode, IDX_W'($urandom_range(0, 7)), ADDR_W'($urandom),
                          esize, req, owner);
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
                if ($urandom_range(0, 39) == 0)
                    steady = !steady;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
